[hw/rtl/rfft_pkg.sv]
// ----------------------------------------------------------------------------
// rfft_pkg: shared constants, types and twiddle table of the radix-2 FFT
// Sizes of the sample store and the datapath, plus the half-wave twiddle
// ROM built at elaboration from a fixed-point series.
// ----------------------------------------------------------------------------
package rfft_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int LG_MAX     = 10;
  localparam int HALF_PTS   = MAX_POINTS / 2;
  localparam int QUART_PTS  = MAX_POINTS / 4;
  localparam int TW_BITS    = 16;
  localparam int TW_W       = TW_BITS + 1;
  localparam int DATA_BITS  = 27;
  localparam int SAMPLE_W   = 16;
  localparam int ENTRY_W    = 2 * DATA_BITS;
  localparam int ADDR_W     = LG_MAX;
  localparam int CNT_W      = LG_MAX + 1;
  localparam int BF_W       = LG_MAX - 1;
  localparam int DIFF_W     = DATA_BITS + 1;
  localparam int PROD_W     = DIFF_W + TW_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int SIZE_W     = 4;

  typedef logic [2*TW_W-1:0] tw_entry_t;
  typedef tw_entry_t [HALF_PTS-1:0] tw_rom_t;

  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] ONE_Q60 = 64'h1000000000000000;

  localparam logic [63:0] CosDiv [12] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
                                          64'd182, 64'd240, 64'd306, 64'd380, 64'd462,
                                          64'd552};
  localparam logic [63:0] SinDiv [12] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
                                          64'd210, 64'd272, 64'd342, 64'd420, 64'd506,
                                          64'd600};

  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [63:0] ah, al, bh, bl, mid;
    ah  = a >> 32;
    al  = a & 64'hFFFFFFFF;
    bh  = b >> 32;
    bl  = b & 64'hFFFFFFFF;
    mid = ah * bl + al * bh + ((al * bl) >> 32);
    return ((ah * bh) << 4) + (mid >> 28);
  endfunction

  function automatic logic [63:0] series_q60(logic [63:0] x, logic odd);
    logic [63:0] term, sum;
    logic        minus;
    term  = odd ? x : ONE_Q60;
    sum   = term;
    minus = 1'b1;
    for (int it = 0; it < 12; it++) begin
      if (odd) begin
        term = mul_q60(mul_q60(term, x), x) / SinDiv[it];
      end else begin
        term = mul_q60(mul_q60(term, x), x) / CosDiv[it];
      end
      sum   = minus ? sum - term : sum + term;
      minus = !minus;
    end
    return sum;
  endfunction

  function automatic logic signed [TW_W-1:0] round_q60(logic [63:0] v, logic neg);
    logic [63:0] m;
    m = (v + (64'h1 << (60 - TW_BITS))) >> (61 - TW_BITS);
    return neg ? -TW_W'(m) : TW_W'(m);
  endfunction

  function automatic tw_rom_t build_rom();
    tw_rom_t     rom;
    logic [63:0] j, k, x, c, s, t;
    logic        neg_cos, swap;
    for (int i = 0; i < HALF_PTS; i++) begin
      j       = 64'(i);
      neg_cos = 1'b0;
      swap    = 1'b0;
      if (j > 64'(QUART_PTS)) begin
        j       = 64'(HALF_PTS) - j;
        neg_cos = 1'b1;
      end
      if (8 * j > 64'(MAX_POINTS)) begin
        k    = 64'(QUART_PTS) - j;
        swap = 1'b1;
      end else begin
        k = j;
      end
      x = (PI_Q60 / HALF_PTS) * k + ((PI_Q60 % HALF_PTS) * k) / HALF_PTS;
      c = series_q60(x, 1'b0);
      s = series_q60(x, 1'b1);
      if (swap) begin
        t = c;
        c = s;
        s = t;
      end
      rom[i] = {round_q60(c, neg_cos), round_q60(s, 1'b0)};
    end
    return rom;
  endfunction

  localparam tw_rom_t TW_ROM = build_rom();

  function automatic logic [ADDR_W-1:0] bitrev(logic [ADDR_W-1:0] v);
    logic [ADDR_W-1:0] r;
    for (int b = 0; b < ADDR_W; b++) begin
      r[b] = v[ADDR_W-1-b];
    end
    return r;
  endfunction

endpackage

[hw/rtl/rfft_if.sv]
// ----------------------------------------------------------------------------
// rfft_if: valid/ready channels of the FFT engine
// Command input, bin output and size configuration channels.
// ----------------------------------------------------------------------------
interface rfft_in_if;
  import rfft_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic signed [SAMPLE_W-1:0] sample_real;
  logic signed [SAMPLE_W-1:0] sample_imag;
  modport source (output valid, command, sample_real, sample_imag, input ready);
  modport sink (input valid, command, sample_real, sample_imag, output ready);
endinterface

interface rfft_out_if;
  import rfft_pkg::*;
  logic                        valid;
  logic                        ready;
  logic                        valid_res;
  logic        [ADDR_W-1:0]    bin_index;
  logic signed [DATA_BITS-1:0] bin_real;
  logic signed [DATA_BITS-1:0] bin_imag;
  logic                        last_bin;
  modport source (output valid, valid_res, bin_index, bin_real, bin_imag, last_bin,
                  input ready);
  modport sink (input valid, valid_res, bin_index, bin_real, bin_imag, last_bin,
                output ready);
endinterface

interface rfft_cfg_if;
  import rfft_pkg::*;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] size_log2;
  modport source (output valid, size_log2, input ready);
  modport sink (input valid, size_log2, output ready);
endinterface

[hw/rtl/rfft_ram.sv]
// ----------------------------------------------------------------------------
// rfft_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rfft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/radix2_fft_engine_core.sv]
// ----------------------------------------------------------------------------
// radix2_fft_engine_core: iterative radix-2 decimation-in-frequency FFT
// A read beat of a ready frame passes through ST_RD, as the store read is
// registered. The load beat that completes a frame of N = 2^L points starts
// the transform, during which the command and configuration channels are not
// ready: the (N/2)*L butterflies run in turn on the single-port-pair
// sample RAM and the one shared 28x17 multiplier (four products per
// butterfly), then the bit-reversed reorder reads and writes back both entries
// at the lower index of each swapped pair and passes over every other index.
// A pending configuration beat holds off the command channel. No clearing
// pass is run.
// ----------------------------------------------------------------------------
module radix2_fft_engine_core (
  input  logic clk_i,
  input  logic rst_ni,
  rfft_in_if.sink    in_i,
  rfft_out_if.source out_o,
  rfft_cfg_if.sink   cfg_i
);
  import rfft_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RD     = 4'd1;
  localparam logic [3:0] ST_BF_RA  = 4'd2;
  localparam logic [3:0] ST_BF_RB  = 4'd3;
  localparam logic [3:0] ST_BF_SUM = 4'd4;
  localparam logic [3:0] ST_BF_M0  = 4'd5;
  localparam logic [3:0] ST_BF_M1  = 4'd6;
  localparam logic [3:0] ST_BF_M2  = 4'd7;
  localparam logic [3:0] ST_BF_M3  = 4'd8;
  localparam logic [3:0] ST_BF_M4  = 4'd9;
  localparam logic [3:0] ST_BF_WB  = 4'd10;
  localparam logic [3:0] ST_SW_RA  = 4'd11;
  localparam logic [3:0] ST_SW_RB  = 4'd12;
  localparam logic [3:0] ST_SW_WA  = 4'd13;
  localparam logic [3:0] ST_SW_WB  = 4'd14;

  localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(1) <<< (TW_BITS - 2);

  logic [3:0]        state_q, state_d;
  logic [SIZE_W-1:0] size_q;
  logic [CNT_W-1:0]  lcnt_q, rcnt_q;
  logic              frame_q;
  logic [SIZE_W-1:0] h_q;
  logic [BF_W-1:0]   j_q;
  logic [ADDR_W-1:0] sa_q;

  logic [ENTRY_W-1:0]         pa_q;
  logic signed [DIFF_W-1:0]   dr_q, di_q;
  logic signed [TW_W-1:0]     twc_q, tws_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [DATA_BITS-1:0] re_q;

  logic                        out_v_q, out_vres_q, out_last_q;
  logic [ADDR_W-1:0]           out_idx_q;
  logic signed [DATA_BITS-1:0] out_re_q, out_im_q;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;

  rfft_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // active size, clamped to 1..LG_MAX
  logic [SIZE_W-1:0] lg;
  logic [CNT_W-1:0]  npts;
  always_comb begin
    if (size_q == '0) begin
      lg = SIZE_W'(1);
    end else if (size_q > SIZE_W'(LG_MAX)) begin
      lg = SIZE_W'(LG_MAX);
    end else begin
      lg = size_q;
    end
    npts = CNT_W'(1) << lg;
  end

  logic in_fire, out_fire, cfg_fire, out_set;
  assign in_i.ready  = (state_q == ST_IDLE) && !cfg_i.valid && (!out_v_q || out_o.ready);
  assign cfg_i.ready = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_fire    = out_o.valid && out_o.ready;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign out_set     = (state_q == ST_RD) ||
                       (in_fire && in_i.command && !(frame_q && rcnt_q < npts));

  // butterfly addressing: j splits into group and position around bit h
  logic [ADDR_W-1:0] kmask, lo, a_addr, b_addr;
  logic [BF_W-1:0]   tw_idx;
  logic              bf_last;
  always_comb begin
    kmask   = (ADDR_W'(1) << h_q) - ADDR_W'(1);
    lo      = ADDR_W'(j_q) & kmask;
    a_addr  = ((ADDR_W'(j_q) & ~kmask) << 1) | lo;
    b_addr  = a_addr | (ADDR_W'(1) << h_q);
    tw_idx  = BF_W'(lo << (SIZE_W'(LG_MAX - 1) - h_q));
    bf_last = ADDR_W'(j_q) == ADDR_W'((npts >> 1) - CNT_W'(1));
  end

  logic [ADDR_W-1:0] rb;
  logic              sw_last;
  assign rb      = bitrev(sa_q) >> (SIZE_W'(LG_MAX) - lg);
  assign sw_last = sa_q == ADDR_W'(npts - CNT_W'(1));

  logic signed [DATA_BITS-1:0] pa_re, pa_im, rd_re, rd_im, sum_re, sum_im;
  logic signed [ACC_W-1:0]     rnd;
  assign pa_re  = pa_q[ENTRY_W-1:DATA_BITS];
  assign pa_im  = pa_q[DATA_BITS-1:0];
  assign rd_re  = ram_rdata[ENTRY_W-1:DATA_BITS];
  assign rd_im  = ram_rdata[DATA_BITS-1:0];
  assign sum_re = pa_re + rd_re;
  assign sum_im = pa_im + rd_im;
  assign rnd    = acc_q + ROUND_C;

  // shared multiplier operand select
  logic signed [DIFF_W-1:0] op_a;
  logic signed [TW_W-1:0]   op_b;
  logic signed [PROD_W-1:0] prod_d;
  always_comb begin
    op_a   = (state_q == ST_BF_M0 || state_q == ST_BF_M3) ? dr_q : di_q;
    op_b   = (state_q == ST_BF_M0 || state_q == ST_BF_M2) ? twc_q : tws_q;
    prod_d = PROD_W'(op_a) * PROD_W'(op_b);
  end

  logic [ADDR_W-1:0] load_idx;
  assign load_idx = (lcnt_q >= npts) ? '0 : lcnt_q[ADDR_W-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = load_idx;
    ram_wdata = {DATA_BITS'(in_i.sample_real), DATA_BITS'(in_i.sample_imag)};
    ram_raddr = rcnt_q[ADDR_W-1:0];
    state_d   = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (!in_i.command) begin
            ram_we = 1'b1;
            if (CNT_W'(load_idx) + CNT_W'(1) == npts) begin
              state_d = ST_BF_RA;
            end
          end else if (frame_q && rcnt_q < npts) begin
            state_d = ST_RD;
          end
        end
      end
      ST_RD:     state_d = ST_IDLE;
      ST_BF_RA: begin
        ram_raddr = a_addr;
        state_d   = ST_BF_RB;
      end
      ST_BF_RB: begin
        ram_raddr = b_addr;
        state_d   = ST_BF_SUM;
      end
      ST_BF_SUM: begin
        ram_we    = 1'b1;
        ram_waddr = a_addr;
        ram_wdata = {sum_re, sum_im};
        state_d   = ST_BF_M0;
      end
      ST_BF_M0:  state_d = ST_BF_M1;
      ST_BF_M1:  state_d = ST_BF_M2;
      ST_BF_M2:  state_d = ST_BF_M3;
      ST_BF_M3:  state_d = ST_BF_M4;
      ST_BF_M4:  state_d = ST_BF_WB;
      ST_BF_WB: begin
        ram_we    = 1'b1;
        ram_waddr = b_addr;
        ram_wdata = {re_q, rnd[DATA_BITS+TW_BITS-2:TW_BITS-1]};
        if (bf_last && h_q == '0) begin
          state_d = ST_SW_RA;
        end else begin
          state_d = ST_BF_RA;
        end
      end
      ST_SW_RA: begin
        ram_raddr = sa_q;
        if (rb > sa_q) begin
          state_d = ST_SW_RB;
        end else if (sw_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_SW_RB: begin
        ram_raddr = rb;
        state_d   = ST_SW_WA;
      end
      ST_SW_WA: begin
        ram_we    = 1'b1;
        ram_waddr = sa_q;
        ram_wdata = ram_rdata;
        state_d   = ST_SW_WB;
      end
      ST_SW_WB: begin
        ram_we    = 1'b1;
        ram_waddr = rb;
        ram_wdata = pa_q;
        state_d   = sw_last ? ST_IDLE : ST_SW_RA;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      size_q  <= SIZE_W'(LG_MAX);
      lcnt_q  <= '0;
      rcnt_q  <= '0;
      frame_q <= 1'b0;
      h_q     <= '0;
      j_q     <= '0;
      sa_q    <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_set) begin
        out_v_q <= 1'b1;
      end else if (out_fire) begin
        out_v_q <= 1'b0;
      end
      // register write drops any partial or finished frame
      if (cfg_fire) begin
        size_q  <= cfg_i.size_log2;
        lcnt_q  <= '0;
        rcnt_q  <= '0;
        frame_q <= 1'b0;
      end else begin
        case (state_q)
          ST_IDLE: begin
            if (in_fire && !in_i.command) begin
              frame_q <= 1'b0;
              rcnt_q  <= '0;
              if (CNT_W'(load_idx) + CNT_W'(1) == npts) begin
                lcnt_q <= '0;
                h_q    <= lg - SIZE_W'(1);
                j_q    <= '0;
              end else begin
                lcnt_q <= CNT_W'(load_idx) + CNT_W'(1);
              end
            end else if (in_fire && frame_q && rcnt_q < npts) begin
              if (rcnt_q == npts - CNT_W'(1)) begin
                rcnt_q  <= '0;
                frame_q <= 1'b0;
              end else begin
                rcnt_q <= rcnt_q + CNT_W'(1);
              end
            end
          end
          ST_BF_WB: begin
            if (bf_last) begin
              j_q  <= '0;
              sa_q <= '0;
              if (h_q != '0) begin
                h_q <= h_q - SIZE_W'(1);
              end
            end else begin
              j_q <= j_q + BF_W'(1);
            end
          end
          ST_SW_RA: begin
            if (!(rb > sa_q)) begin
              if (sw_last) begin
                frame_q <= 1'b1;
              end else begin
                sa_q <= sa_q + ADDR_W'(1);
              end
            end
          end
          ST_SW_WB: begin
            if (sw_last) begin
              frame_q <= 1'b1;
            end else begin
              sa_q <= sa_q + ADDR_W'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // datapath and output payload
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && in_i.command) begin
          if (frame_q && rcnt_q < npts) begin
            out_idx_q  <= rcnt_q[ADDR_W-1:0];
            out_last_q <= rcnt_q == npts - CNT_W'(1);
          end else begin
            out_vres_q <= 1'b0;
            out_idx_q  <= '0;
            out_last_q <= 1'b0;
            out_re_q   <= '0;
            out_im_q   <= '0;
          end
        end
      end
      ST_RD: begin
        out_vres_q <= 1'b1;
        out_re_q   <= rd_re;
        out_im_q   <= rd_im;
      end
      ST_BF_RA: begin
        twc_q <= TW_ROM[tw_idx][2*TW_W-1:TW_W];
        tws_q <= TW_ROM[tw_idx][TW_W-1:0];
      end
      ST_BF_RB:  pa_q <= ram_rdata;
      ST_BF_SUM: begin
        dr_q <= DIFF_W'(pa_re) - DIFF_W'(rd_re);
        di_q <= DIFF_W'(pa_im) - DIFF_W'(rd_im);
      end
      ST_BF_M1:  acc_q <= ACC_W'(prod_q);
      ST_BF_M2:  acc_q <= acc_q + ACC_W'(prod_q);
      ST_BF_M3: begin
        re_q  <= rnd[DATA_BITS+TW_BITS-2:TW_BITS-1];
        acc_q <= ACC_W'(prod_q);
      end
      ST_BF_M4:  acc_q <= acc_q - ACC_W'(prod_q);
      ST_SW_RB:  pa_q <= ram_rdata;
      default: ;
    endcase
  end

  assign out_o.valid     = out_v_q;
  assign out_o.valid_res = out_vres_q;
  assign out_o.bin_index = out_idx_q;
  assign out_o.bin_real  = out_re_q;
  assign out_o.bin_imag  = out_im_q;
  assign out_o.last_bin  = out_last_q;

`ifndef SYNTHESIS
  a_no_frame_in_transform: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && state_q != ST_RD) |-> !frame_q)
    else $error("frame marked ready during transform");
  a_load_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lcnt_q < npts)
    else $error("load count out of range");
  a_last_clears_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last_bin) |-> !frame_q)
    else $error("frame still ready after last bin");
  a_frame_starts_transform: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !in_i.command && !cfg_fire && CNT_W'(load_idx) + CNT_W'(1) == npts)
    |=> state_q == ST_BF_RA)
    else $error("full frame did not start transform");
`endif

endmodule
